/* rtl/gcast_pkg.sv */
// shared constants, types and helpers for the grid ray caster
`default_nettype none
package gcast_pkg;

   localparam int MAP_W     = 64;
   localparam int MAP_H     = 64;
   localparam int FRAC_BITS = 16;
   localparam int COL_W     = $clog2(MAP_W);
   localparam int ROW_W     = $clog2(MAP_H);
   localparam int CELL_W    = 6;
   localparam int POS_W     = 22;
   localparam int DIR_W     = 18;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int EPS_RAW   = (ONE + 5000) / 10000;
   localparam int EPS       = (EPS_RAW > 0) ? EPS_RAW : 1;
   localparam int SAT_LIM   = (MAP_W + MAP_H + 64) * ONE;
   localparam int CRD_W     = POS_W + 2;
   localparam int N_W       = 32;
   localparam int PROD_W    = DIR_W + CRD_W;
   localparam int Q_W       = 2 * DIR_W - 1;
   localparam int DVS_W     = DIR_W;
   localparam int SQ_W      = 2 * POS_W;
   localparam int ACC_W     = SQ_W + 1;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLR, OP_LOAD, OP_WRD, OP_WWR, OP_SETUP, OP_DIVA, OP_FINA,
      OP_DIVB, OP_FINB, OP_RD, OP_CHK, OP_NEXT, OP_MAG, OP_MUL, OP_ACC, OP_RESULT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_cast;
      logic cell_ok;
      logic dm_zero;
      logic div_done;
      logic run;
      logic solid;
      logic last_pass;
      logic both_hit;
      logic rsp_busy;
   } sts_type;

   function automatic logic signed [N_W-1:0] sat_q(input logic [Q_W-1:0] mag,
                                                   input logic neg);
      logic signed [N_W-1:0] v;
      if (mag > Q_W'(SAT_LIM)) v = N_W'(SAT_LIM);
      else v = N_W'(mag);
      return neg ? -v : v;
   endfunction

endpackage
`default_nettype wire

/* rtl/gcast_ram.sv */
// generic ram, one write port, one registered read port
`default_nettype none
module gcast_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

/* rtl/gcast_div.sv */
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module gcast_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [gcast_pkg::Q_W-1:0]   dividend,
   input  wire logic [gcast_pkg::DVS_W-1:0] divisor,
   output logic      [gcast_pkg::Q_W-1:0]   quotient,
   output logic                           done
);
   import gcast_pkg::*;

   localparam int CNT_W = $clog2(Q_W + 1);

   logic [Q_W-1:0]   quo_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DVS_W:0]   trial_in;
   logic             ge_in;
   logic [DVS_W:0]   diff_in;

   assign trial_in = {rem_ff, quo_ff[Q_W-1]};
   assign ge_in    = trial_in >= {1'b0, dvs_ff};
   assign diff_in  = trial_in - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
            cnt_ff  <= CNT_W'(Q_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge_in ? diff_in[DVS_W-1:0] : trial_in[DVS_W-1:0];
            quo_ff <= {quo_ff[Q_W-2:0], ge_in};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule
`default_nettype wire

/* rtl/gcast_dp.sv */
// datapath: map memory, slope divider, grid walk, distance compare, result word
`default_nettype none
module gcast_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire gcast_pkg::cmd_type                 cmd,
   output gcast_pkg::sts_type                      sts,
   input  wire logic                               req_opcode,
   input  wire logic [gcast_pkg::CELL_W-1:0]       req_cell_x,
   input  wire logic [gcast_pkg::CELL_W-1:0]       req_cell_y,
   input  wire logic                               req_cell_solid,
   input  wire logic [gcast_pkg::POS_W-1:0]        req_origin_x,
   input  wire logic [gcast_pkg::POS_W-1:0]        req_origin_y,
   input  wire logic signed [gcast_pkg::DIR_W-1:0] req_dir_x,
   input  wire logic signed [gcast_pkg::DIR_W-1:0] req_dir_y,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_hit,
   output logic [gcast_pkg::POS_W-1:0]             rsp_hit_x,
   output logic [gcast_pkg::POS_W-1:0]             rsp_hit_y,
   output logic                                    rsp_hit_axis
);
   import gcast_pkg::*;

   localparam logic signed [CRD_W-1:0] LIM_X = CRD_W'(MAP_W * ONE);
   localparam logic signed [CRD_W-1:0] LIM_Y = CRD_W'(MAP_H * ONE);

   logic                    op_ff;
   logic [CELL_W-1:0]       cx_ff, cy_ff;
   logic                    solid_ff;
   logic [POS_W-1:0]        ox_ff, oy_ff;
   logic signed [DIR_W-1:0] dx_ff, dy_ff;
   logic                    pass_ff;
   logic [ROW_W-1:0]        clr_row_ff;
   logic signed [CRD_W-1:0] m_ff;
   logic signed [N_W-1:0]   n_ff, step_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                    sign_ff;
   logic                    cvalid_ff;
   logic [COL_W-1:0]        col_ff;
   logic                    vh_ff, hh_ff;
   logic [POS_W-1:0]        vx_ff, vy_ff, hx_ff, hy_ff;
   logic [POS_W-1:0]        mag_ff;
   logic [SQ_W-1:0]         sq_ff;
   logic [ACC_W-1:0]        accv_ff, acch_ff;
   logic                    rv_ff, rhit_ff, raxis_ff;
   logic [POS_W-1:0]        rx_ff, ry_ff;

   logic [POS_W-1:0]        om_in, on_in;
   logic signed [DIR_W-1:0] dm_in, dn_in;
   logic [DIR_W-1:0]        adm_in, adn_in;
   logic signed [CRD_W-1:0] base_in, start_in, diff_in, mlim_in;
   logic [PROD_W-1:0]       aprod_in;
   logic                    div_go_in;
   logic [Q_W-1:0]          dvd_in, quo_in;
   logic                    div_done_in;
   logic signed [N_W-1:0]   px_in, py_in;
   logic                    in_map_in;
   logic                    we_in;
   logic [ROW_W-1:0]        waddr_in, raddr_in;
   logic [MAP_W-1:0]        wdata_in, row_in, row_mod_in;
   logic                    solid_in;
   logic signed [POS_W:0]   d_in;
   logic [POS_W-1:0]        a_in, b_in;
   logic                    pick_v_in;

   assign om_in  = pass_ff ? oy_ff : ox_ff;
   assign on_in  = pass_ff ? ox_ff : oy_ff;
   assign dm_in  = pass_ff ? dy_ff : dx_ff;
   assign dn_in  = pass_ff ? dx_ff : dy_ff;
   assign adm_in = dm_in[DIR_W-1] ? DIR_W'(-dm_in) : DIR_W'(dm_in);
   assign adn_in = dn_in[DIR_W-1] ? DIR_W'(-dn_in) : DIR_W'(dn_in);
   assign mlim_in = pass_ff ? LIM_Y : LIM_X;

   assign base_in  = $signed({2'b00, om_in[POS_W-1:FRAC_BITS], FRAC_BITS'(0)});
   assign start_in = dm_in[DIR_W-1] ? base_in - CRD_W'(EPS) : base_in + CRD_W'(ONE);
   assign diff_in  = start_in - $signed({2'b00, om_in});

   assign aprod_in = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign div_go_in = (cmd.op == OP_DIVA) || (cmd.op == OP_DIVB);
   assign dvd_in = (cmd.op == OP_DIVA) ? aprod_in[Q_W-1:0]
                                       : (Q_W'(adn_in) << FRAC_BITS);

   gcast_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_in),
      .dividend (dvd_in),
      .divisor  (adm_in),
      .quotient (quo_in),
      .done     (div_done_in)
   );

   assign px_in = pass_ff ? n_ff : N_W'(m_ff);
   assign py_in = pass_ff ? N_W'(m_ff) : n_ff;
   assign in_map_in = !px_in[N_W-1] && !py_in[N_W-1]
                   && (px_in[N_W-2:FRAC_BITS] < (N_W-1-FRAC_BITS)'(MAP_W))
                   && (py_in[N_W-2:FRAC_BITS] < (N_W-1-FRAC_BITS)'(MAP_H));

   always_comb begin
      row_mod_in = row_in;
      row_mod_in[cx_ff[COL_W-1:0]] = solid_ff;
   end

   assign we_in    = (cmd.op == OP_CLR) || (cmd.op == OP_WWR);
   assign waddr_in = (cmd.op == OP_CLR) ? clr_row_ff : cy_ff[ROW_W-1:0];
   assign wdata_in = (cmd.op == OP_CLR) ? '0 : row_mod_in;
   assign raddr_in = (cmd.op == OP_RD) ? py_in[FRAC_BITS+ROW_W-1:FRAC_BITS]
                                       : cy_ff[ROW_W-1:0];

   gcast_ram #(.WIDTH(MAP_W), .DEPTH(MAP_H)) u_map (
      .clock (clock),
      .we    (we_in),
      .waddr (waddr_in),
      .wdata (wdata_in),
      .raddr (raddr_in),
      .rdata (row_in)
   );

   assign solid_in = cvalid_ff && row_in[col_ff];

   always_comb begin
      unique case (cmd.idx)
         2'd0:    begin a_in = vx_ff; b_in = ox_ff; end
         2'd1:    begin a_in = vy_ff; b_in = oy_ff; end
         2'd2:    begin a_in = hx_ff; b_in = ox_ff; end
         default: begin a_in = hy_ff; b_in = oy_ff; end
      endcase
   end
   assign d_in = $signed({1'b0, a_in}) - $signed({1'b0, b_in});
   assign pick_v_in = vh_ff && (!hh_ff || (accv_ff <= acch_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_row_ff <= '0;
         pass_ff    <= 1'b0;
         rv_ff      <= 1'b0;
         vh_ff      <= 1'b0;
         hh_ff      <= 1'b0;
      end else begin
         if (rv_ff && !rsp_stall) begin
            rv_ff <= 1'b0;
         end
         unique case (cmd.op)
            OP_CLR: begin
               clr_row_ff <= clr_row_ff + 1'b1;
            end
            OP_LOAD: begin
               op_ff    <= req_opcode;
               cx_ff    <= req_cell_x;
               cy_ff    <= req_cell_y;
               solid_ff <= req_cell_solid;
               ox_ff    <= req_origin_x;
               oy_ff    <= req_origin_y;
               dx_ff    <= req_dir_x;
               dy_ff    <= req_dir_y;
               pass_ff  <= 1'b0;
               vh_ff    <= 1'b0;
               hh_ff    <= 1'b0;
               accv_ff  <= '0;
               acch_ff  <= '0;
            end
            OP_SETUP: begin
               m_ff    <= start_in;
               prod_ff <= PROD_W'(dn_in) * PROD_W'(diff_in);
            end
            OP_DIVA: begin
               sign_ff <= prod_ff[PROD_W-1] ^ dm_in[DIR_W-1];
            end
            OP_FINA: begin
               n_ff <= $signed({{(N_W-POS_W){1'b0}}, on_in}) + sat_q(quo_in, sign_ff);
            end
            OP_DIVB: begin
               sign_ff <= dn_in[DIR_W-1];
            end
            OP_FINB: begin
               step_ff <= sat_q(quo_in, sign_ff);
            end
            OP_RD: begin
               cvalid_ff <= in_map_in;
               col_ff    <= px_in[FRAC_BITS+COL_W-1:FRAC_BITS];
            end
            OP_CHK: begin
               if (solid_in) begin
                  if (pass_ff) begin
                     hh_ff <= 1'b1;
                     hx_ff <= n_ff[POS_W-1:0];
                     hy_ff <= m_ff[POS_W-1:0];
                  end else begin
                     vh_ff <= 1'b1;
                     vx_ff <= m_ff[POS_W-1:0];
                     vy_ff <= n_ff[POS_W-1:0];
                  end
               end else begin
                  m_ff <= dm_in[DIR_W-1] ? m_ff - CRD_W'(ONE) : m_ff + CRD_W'(ONE);
                  n_ff <= n_ff + step_ff;
               end
            end
            OP_NEXT: begin
               pass_ff <= 1'b1;
            end
            OP_MAG: begin
               mag_ff <= d_in[POS_W] ? POS_W'(-d_in) : POS_W'(d_in);
            end
            OP_MUL: begin
               sq_ff <= SQ_W'(mag_ff) * SQ_W'(mag_ff);
            end
            OP_ACC: begin
               if (cmd.idx[1]) acch_ff <= acch_ff + ACC_W'(sq_ff);
               else accv_ff <= accv_ff + ACC_W'(sq_ff);
            end
            OP_RESULT: begin
               rv_ff    <= 1'b1;
               rhit_ff  <= vh_ff || hh_ff;
               rx_ff    <= pick_v_in ? vx_ff : (hh_ff ? hx_ff : '0);
               ry_ff    <= pick_v_in ? vy_ff : (hh_ff ? hy_ff : '0);
               raxis_ff <= !pick_v_in && hh_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign sts.clr_last  = clr_row_ff == ROW_W'(MAP_H - 1);
   assign sts.is_cast   = op_ff;
   assign sts.cell_ok   = (32'(cx_ff) < 32'(MAP_W)) && (32'(cy_ff) < 32'(MAP_H));
   assign sts.dm_zero   = dm_in == '0;
   assign sts.div_done  = div_done_in;
   assign sts.run       = !m_ff[CRD_W-1] && (m_ff < mlim_in);
   assign sts.solid     = solid_in;
   assign sts.last_pass = pass_ff;
   assign sts.both_hit  = vh_ff && hh_ff;
   assign sts.rsp_busy  = rv_ff;

   assign rsp_valid    = rv_ff;
   assign rsp_hit      = rhit_ff;
   assign rsp_hit_x    = rx_ff;
   assign rsp_hit_y    = ry_ff;
   assign rsp_hit_axis = raxis_ff;
endmodule
`default_nettype wire

/* rtl/gcast_ctrl.sv */
// controller state machine sequencing map writes and ray casts
`default_nettype none
module gcast_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire gcast_pkg::sts_type  sts,
   output gcast_pkg::cmd_type       cmd
);
   import gcast_pkg::*;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_DECODE, S_WR_RD, S_WR_WR, S_PSET, S_DIVA, S_DIVA_W,
      S_DIVB, S_DIVB_W, S_WRD, S_WCHK, S_PEND, S_MAG, S_MUL, S_ACC, S_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd.op   = OP_NONE;
      cmd.idx  = idx_ff;
      unique case (state_ff)
         S_CLR: begin
            cmd.op = OP_CLR;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_cast) state_in = S_PSET;
            else if (sts.cell_ok) state_in = S_WR_RD;
            else state_in = S_IDLE;
         end
         S_WR_RD: begin
            cmd.op   = OP_WRD;
            state_in = S_WR_WR;
         end
         S_WR_WR: begin
            cmd.op   = OP_WWR;
            state_in = S_IDLE;
         end
         S_PSET: begin
            if (sts.dm_zero) state_in = S_PEND;
            else begin
               cmd.op   = OP_SETUP;
               state_in = S_DIVA;
            end
         end
         S_DIVA: begin
            cmd.op   = OP_DIVA;
            state_in = S_DIVA_W;
         end
         S_DIVA_W: begin
            if (sts.div_done) begin
               cmd.op   = OP_FINA;
               state_in = S_DIVB;
            end
         end
         S_DIVB: begin
            cmd.op   = OP_DIVB;
            state_in = S_DIVB_W;
         end
         S_DIVB_W: begin
            if (sts.div_done) begin
               cmd.op   = OP_FINB;
               state_in = S_WRD;
            end
         end
         S_WRD: begin
            if (!sts.run) state_in = S_PEND;
            else begin
               cmd.op   = OP_RD;
               state_in = S_WCHK;
            end
         end
         S_WCHK: begin
            cmd.op   = OP_CHK;
            state_in = sts.solid ? S_PEND : S_WRD;
         end
         S_PEND: begin
            if (!sts.last_pass) begin
               cmd.op   = OP_NEXT;
               state_in = S_PSET;
            end else if (sts.both_hit) begin
               idx_in   = 2'd0;
               state_in = S_MAG;
            end else begin
               state_in = S_OUT;
            end
         end
         S_MAG: begin
            cmd.op   = OP_MAG;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op   = OP_MUL;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = OP_ACC;
            if (idx_ff == 2'd3) state_in = S_OUT;
            else begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_MAG;
            end
         end
         S_OUT: begin
            if (!sts.rsp_busy) begin
               cmd.op   = OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         idx_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
endmodule
`default_nettype wire

/* rtl/grid_ray_cast_core.sv */
// top level of the grid ray caster: controller, datapath and checks
// one word at a time; a map write reads the target row and then writes it back; a cast runs
// two serial divisions per nonzero axis, then a map read and a test for each grid line
// crossed, plus a distance compare when both axes hit
// the result sits in an output register, so the next word is taken while it waits
// after reset the map is cleared one row per cycle with req_stall high
`default_nettype none
module grid_ray_cast_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_opcode,
   input  wire logic [gcast_pkg::CELL_W-1:0]       req_cell_x,
   input  wire logic [gcast_pkg::CELL_W-1:0]       req_cell_y,
   input  wire logic                               req_cell_solid,
   input  wire logic [gcast_pkg::POS_W-1:0]        req_origin_x,
   input  wire logic [gcast_pkg::POS_W-1:0]        req_origin_y,
   input  wire logic signed [gcast_pkg::DIR_W-1:0] req_dir_x,
   input  wire logic signed [gcast_pkg::DIR_W-1:0] req_dir_y,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_hit,
   output logic [gcast_pkg::POS_W-1:0]             rsp_hit_x,
   output logic [gcast_pkg::POS_W-1:0]             rsp_hit_y,
   output logic                                    rsp_hit_axis
);
   import gcast_pkg::*;

   cmd_type cmd;
   sts_type sts;

   gcast_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gcast_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_opcode     (req_opcode),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_cell_solid (req_cell_solid),
      .req_origin_x   (req_origin_x),
      .req_origin_y   (req_origin_y),
      .req_dir_x      (req_dir_x),
      .req_dir_y      (req_dir_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_hit_x      (rsp_hit_x),
      .rsp_hit_y      (rsp_hit_y),
      .rsp_hit_axis   (rsp_hit_axis)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while a word is in progress");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input open during map clear");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_x == '0 && rsp_hit_y == '0 && !rsp_hit_axis)
      else $error("miss word carries a point");
`endif
endmodule
`default_nettype wire
